@@ sv/kalman_filter_step_core_macros.svh @@
// ---------------------------------------------------------------------------
// Kalman filter step core - assertion macros
// Shared property shorthands for the core's checks.
// ---------------------------------------------------------------------------
`ifndef KALMAN_FILTER_STEP_CORE_MACROS_SVH
`define KALMAN_FILTER_STEP_CORE_MACROS_SVH

// Same-cycle implication, masked while in reset
`define KFSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset
`define KFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kfs_pkg.sv @@
// ---------------------------------------------------------------------------
// kfs_pkg
// Types, constants and the micro-program of the Kalman filter step core.
// ---------------------------------------------------------------------------
package kfs_pkg;

  localparam int DW       = 32;
  localparam int CW       = 64;
  localparam int CFG_N    = 5;
  localparam int CFG_IW   = 3;
  localparam int IDX_W    = 5;
  localparam int RAM_D    = 32;
  localparam int PROG_LEN = 63;
  localparam int PC_W     = 6;

  localparam logic [CW-1:0] CFG_RST_IDENT = 64'h0100_0000_0000_0100;
  localparam logic [CW-1:0] CFG_RST_ONES  = 64'h0100_0100_0100_0100;

  typedef enum logic [1:0] {M_MUL, M_ADD, M_SUB, M_DIV} mode_t;
  typedef enum logic [1:0] {S_RAM, S_COEF, S_EXT} src_t;
  typedef enum logic [1:0] {D_NONE, D_RAM, D_STATE} dst_t;

  typedef struct packed {
    src_t             src;
    logic [IDX_W-1:0] idx;
  } opnd_t;

  typedef struct packed {
    mode_t            mode;
    opnd_t            a;
    opnd_t            b;
    logic             acc;
    logic             sh16;
    dst_t             dk;
    logic [IDX_W-1:0] dst;
  } ins_t;

  typedef struct packed {
    logic accept;
    logic ex;
    logic wb;
    logic div_start;
    logic div_wr;
    logic out_load;
    ins_t ins;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_EX, ST_WB, ST_DIV, ST_OUT} ctl_state_t;

  // coefficient index: register * 4 + entry
  localparam logic [IDX_W-1:0] C_A00 = 5'd0,  C_A01 = 5'd1,  C_A10 = 5'd2,  C_A11 = 5'd3;
  localparam logic [IDX_W-1:0] C_B00 = 5'd4,  C_B01 = 5'd5,  C_B10 = 5'd6,  C_B11 = 5'd7;
  localparam logic [IDX_W-1:0] C_H00 = 5'd8,  C_H01 = 5'd9;
  localparam logic [IDX_W-1:0] C_Q00 = 5'd12, C_Q01 = 5'd13, C_Q10 = 5'd14, C_Q11 = 5'd15;
  localparam logic [IDX_W-1:0] C_R00 = 5'd16;
  localparam logic [2:0]       CREG_Q = 3'd3;

  // state and input words; the state ones double as write targets
  localparam logic [IDX_W-1:0] E_X0 = 5'd0, E_X1 = 5'd1;
  localparam logic [IDX_W-1:0] E_P00 = 5'd2, E_P01 = 5'd3, E_P10 = 5'd4, E_P11 = 5'd5;
  localparam logic [IDX_W-1:0] E_Z0 = 5'd6, E_Z1 = 5'd7, E_U0 = 5'd8, E_U1 = 5'd9;

  // scratch RAM map
  localparam logic [IDX_W-1:0] R_XP0 = 5'd0,  R_XP1 = 5'd1;
  localparam logic [IDX_W-1:0] R_T00 = 5'd2,  R_T01 = 5'd3,  R_T10 = 5'd4,  R_T11 = 5'd5;
  localparam logic [IDX_W-1:0] R_PP00 = 5'd6, R_PP01 = 5'd7, R_PP10 = 5'd8, R_PP11 = 5'd9;
  localparam logic [IDX_W-1:0] R_Y = 5'd10,   R_PH0 = 5'd11, R_PH1 = 5'd12, R_S = 5'd13;
  localparam logic [IDX_W-1:0] R_INV = 5'd14, R_K0 = 5'd15,  R_K1 = 5'd16,  R_INN = 5'd17;
  localparam logic [IDX_W-1:0] R_KH00 = 5'd18, R_KH01 = 5'd19, R_KH10 = 5'd20, R_KH11 = 5'd21;
  localparam logic [IDX_W-1:0] R_TA = 5'd22,  R_TB = 5'd23;

  localparam logic SH8 = 1'b0, SH16 = 1'b1;

  function automatic ins_t mk(mode_t m, src_t as, logic [IDX_W-1:0] ai, src_t bs,
                              logic [IDX_W-1:0] bi, logic acc, logic sh16, dst_t dk,
                              logic [IDX_W-1:0] d);
    ins_t r;
    r.mode  = m;
    r.a.src = as;
    r.a.idx = ai;
    r.b.src = bs;
    r.b.idx = bi;
    r.acc   = acc;
    r.sh16  = sh16;
    r.dk    = dk;
    r.dst   = d;
    return r;
  endfunction

  // first product of a two-term sum
  function automatic ins_t mp(src_t as, logic [IDX_W-1:0] ai, src_t bs,
                              logic [IDX_W-1:0] bi, logic sh);
    return mk(M_MUL, as, ai, bs, bi, 1'b0, sh, D_NONE, R_TA);
  endfunction

  // second product, summed and written
  function automatic ins_t ma(src_t as, logic [IDX_W-1:0] ai, src_t bs,
                              logic [IDX_W-1:0] bi, logic sh, dst_t dk, logic [IDX_W-1:0] d);
    return mk(M_MUL, as, ai, bs, bi, 1'b1, sh, dk, d);
  endfunction

  // single product written
  function automatic ins_t m1(src_t as, logic [IDX_W-1:0] ai, src_t bs,
                              logic [IDX_W-1:0] bi, logic sh, dst_t dk, logic [IDX_W-1:0] d);
    return mk(M_MUL, as, ai, bs, bi, 1'b0, sh, dk, d);
  endfunction

  function automatic ins_t ad(src_t as, logic [IDX_W-1:0] ai, src_t bs,
                              logic [IDX_W-1:0] bi, dst_t dk, logic [IDX_W-1:0] d);
    return mk(M_ADD, as, ai, bs, bi, 1'b0, SH8, dk, d);
  endfunction

  function automatic ins_t sb(src_t as, logic [IDX_W-1:0] ai, src_t bs,
                              logic [IDX_W-1:0] bi, dst_t dk, logic [IDX_W-1:0] d);
    return mk(M_SUB, as, ai, bs, bi, 1'b0, SH8, dk, d);
  endfunction

  // one filter step for a 2-entry state and one measurement
  function automatic ins_t ucode(logic [PC_W-1:0] pc);
    ins_t r;
    r = mk(M_ADD, S_RAM, R_TA, S_RAM, R_TA, 1'b0, SH8, D_NONE, R_TA);
    case (pc)
      // predicted state
      6'd0:  r = mp(S_COEF, C_A00, S_EXT, E_X0, SH8);
      6'd1:  r = ma(S_COEF, C_A01, S_EXT, E_X1, SH8, D_RAM, R_TA);
      6'd2:  r = mp(S_COEF, C_B00, S_EXT, E_U0, SH8);
      6'd3:  r = ma(S_COEF, C_B01, S_EXT, E_U1, SH8, D_RAM, R_TB);
      6'd4:  r = ad(S_RAM, R_TA, S_RAM, R_TB, D_RAM, R_XP0);
      6'd5:  r = mp(S_COEF, C_A10, S_EXT, E_X0, SH8);
      6'd6:  r = ma(S_COEF, C_A11, S_EXT, E_X1, SH8, D_RAM, R_TA);
      6'd7:  r = mp(S_COEF, C_B10, S_EXT, E_U0, SH8);
      6'd8:  r = ma(S_COEF, C_B11, S_EXT, E_U1, SH8, D_RAM, R_TB);
      6'd9:  r = ad(S_RAM, R_TA, S_RAM, R_TB, D_RAM, R_XP1);
      // A * P
      6'd10: r = mp(S_COEF, C_A00, S_EXT, E_P00, SH8);
      6'd11: r = ma(S_COEF, C_A01, S_EXT, E_P10, SH8, D_RAM, R_T00);
      6'd12: r = mp(S_COEF, C_A00, S_EXT, E_P01, SH8);
      6'd13: r = ma(S_COEF, C_A01, S_EXT, E_P11, SH8, D_RAM, R_T01);
      6'd14: r = mp(S_COEF, C_A10, S_EXT, E_P00, SH8);
      6'd15: r = ma(S_COEF, C_A11, S_EXT, E_P10, SH8, D_RAM, R_T10);
      6'd16: r = mp(S_COEF, C_A10, S_EXT, E_P01, SH8);
      6'd17: r = ma(S_COEF, C_A11, S_EXT, E_P11, SH8, D_RAM, R_T11);
      // (A P) A^T + Q
      6'd18: r = mp(S_RAM, R_T00, S_COEF, C_A00, SH8);
      6'd19: r = ma(S_RAM, R_T01, S_COEF, C_A01, SH8, D_RAM, R_TA);
      6'd20: r = ad(S_RAM, R_TA, S_COEF, C_Q00, D_RAM, R_PP00);
      6'd21: r = mp(S_RAM, R_T00, S_COEF, C_A10, SH8);
      6'd22: r = ma(S_RAM, R_T01, S_COEF, C_A11, SH8, D_RAM, R_TA);
      6'd23: r = ad(S_RAM, R_TA, S_COEF, C_Q01, D_RAM, R_PP01);
      6'd24: r = mp(S_RAM, R_T10, S_COEF, C_A00, SH8);
      6'd25: r = ma(S_RAM, R_T11, S_COEF, C_A01, SH8, D_RAM, R_TA);
      6'd26: r = ad(S_RAM, R_TA, S_COEF, C_Q10, D_RAM, R_PP10);
      6'd27: r = mp(S_RAM, R_T10, S_COEF, C_A10, SH8);
      6'd28: r = ma(S_RAM, R_T11, S_COEF, C_A11, SH8, D_RAM, R_TA);
      6'd29: r = ad(S_RAM, R_TA, S_COEF, C_Q11, D_RAM, R_PP11);
      // H x', P' H^T, innovation covariance
      6'd30: r = mp(S_COEF, C_H00, S_RAM, R_XP0, SH8);
      6'd31: r = ma(S_COEF, C_H01, S_RAM, R_XP1, SH8, D_RAM, R_Y);
      6'd32: r = mp(S_RAM, R_PP00, S_COEF, C_H00, SH8);
      6'd33: r = ma(S_RAM, R_PP01, S_COEF, C_H01, SH8, D_RAM, R_PH0);
      6'd34: r = mp(S_RAM, R_PP10, S_COEF, C_H00, SH8);
      6'd35: r = ma(S_RAM, R_PP11, S_COEF, C_H01, SH8, D_RAM, R_PH1);
      6'd36: r = mp(S_COEF, C_H00, S_RAM, R_PH0, SH8);
      6'd37: r = ma(S_COEF, C_H01, S_RAM, R_PH1, SH8, D_RAM, R_TA);
      6'd38: r = ad(S_RAM, R_TA, S_COEF, C_R00, D_RAM, R_S);
      6'd39: r = mk(M_DIV, S_RAM, R_S, S_RAM, R_S, 1'b0, SH8, D_RAM, R_INV);
      // gain and innovation
      6'd40: r = m1(S_RAM, R_PH0, S_RAM, R_INV, SH16, D_RAM, R_K0);
      6'd41: r = m1(S_RAM, R_PH1, S_RAM, R_INV, SH16, D_RAM, R_K1);
      6'd42: r = sb(S_EXT, E_Z0, S_RAM, R_Y, D_RAM, R_INN);
      // new state
      6'd43: r = m1(S_RAM, R_K0, S_RAM, R_INN, SH16, D_RAM, R_TA);
      6'd44: r = ad(S_RAM, R_XP0, S_RAM, R_TA, D_STATE, E_X0);
      6'd45: r = m1(S_RAM, R_K1, S_RAM, R_INN, SH16, D_RAM, R_TA);
      6'd46: r = ad(S_RAM, R_XP1, S_RAM, R_TA, D_STATE, E_X1);
      // K H
      6'd47: r = m1(S_RAM, R_K0, S_COEF, C_H00, SH8, D_RAM, R_KH00);
      6'd48: r = m1(S_RAM, R_K0, S_COEF, C_H01, SH8, D_RAM, R_KH01);
      6'd49: r = m1(S_RAM, R_K1, S_COEF, C_H00, SH8, D_RAM, R_KH10);
      6'd50: r = m1(S_RAM, R_K1, S_COEF, C_H01, SH8, D_RAM, R_KH11);
      // new covariance
      6'd51: r = mp(S_RAM, R_KH00, S_RAM, R_PP00, SH16);
      6'd52: r = ma(S_RAM, R_KH01, S_RAM, R_PP10, SH16, D_RAM, R_TA);
      6'd53: r = sb(S_RAM, R_PP00, S_RAM, R_TA, D_STATE, E_P00);
      6'd54: r = mp(S_RAM, R_KH00, S_RAM, R_PP01, SH16);
      6'd55: r = ma(S_RAM, R_KH01, S_RAM, R_PP11, SH16, D_RAM, R_TA);
      6'd56: r = sb(S_RAM, R_PP01, S_RAM, R_TA, D_STATE, E_P01);
      6'd57: r = mp(S_RAM, R_KH10, S_RAM, R_PP00, SH16);
      6'd58: r = ma(S_RAM, R_KH11, S_RAM, R_PP10, SH16, D_RAM, R_TA);
      6'd59: r = sb(S_RAM, R_PP10, S_RAM, R_TA, D_STATE, E_P10);
      6'd60: r = mp(S_RAM, R_KH10, S_RAM, R_PP01, SH16);
      6'd61: r = ma(S_RAM, R_KH11, S_RAM, R_PP11, SH16, D_RAM, R_TA);
      6'd62: r = sb(S_RAM, R_PP11, S_RAM, R_TA, D_STATE, E_P11);
      default: r = mk(M_ADD, S_RAM, R_TA, S_RAM, R_TA, 1'b0, SH8, D_NONE, R_TA);
    endcase
    return r;
  endfunction

endpackage

@@ sv/kfs_ram.sv @@
// ---------------------------------------------------------------------------
// kfs_ram
// Generic RAM, one write port and two registered read ports.
// ---------------------------------------------------------------------------
module kfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ sv/kfs_div.sv @@
// ---------------------------------------------------------------------------
// kfs_div
// Bit-serial reciprocal: 2^32 / divisor, truncated toward zero and clipped.
// ---------------------------------------------------------------------------
module kfs_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [kfs_pkg::DW-1:0]   divisor,
  output logic                     done,
  output logic [kfs_pkg::DW-1:0]   quo,
  output logic                     clip,
  output logic                     zero
);

  localparam logic [5:0] DIV_STEPS = 6'd33;

  logic        busy_r, done_r, neg_r, zero_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [32:0] q_r;
  logic [31:0] d_r;
  logic [32:0] rem_sh;
  logic        ge;

  // dividend is a single one at bit 32, fed in on the first step
  assign rem_sh = {rem_r, cnt_r == DIV_STEPS};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (divisor == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= DIV_STEPS;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // the remainder stays below the divisor, so it fits in 32 bits
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= divisor[31];
      zero_r <= divisor == '0;
      d_r    <= divisor[31] ? (~divisor + 32'd1) : divisor;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, d_r}) : rem_sh[31:0];
      q_r   <= {q_r[31:0], ge};
    end
  end

  always_comb begin
    quo  = '0;
    clip = 1'b0;
    if (zero_r) begin
      quo = '0;
    end else if (!neg_r) begin
      if (q_r > 33'h0_7FFF_FFFF) begin
        quo  = 32'h7FFF_FFFF;
        clip = 1'b1;
      end else begin
        quo = q_r[31:0];
      end
    end else begin
      if (q_r > 33'h0_8000_0000) begin
        quo  = 32'h8000_0000;
        clip = 1'b1;
      end else begin
        quo = ~q_r[31:0] + 32'd1;
      end
    end
  end

  assign done = done_r;
  assign zero = zero_r;

endmodule

@@ sv/kfs_dp.sv @@
// ---------------------------------------------------------------------------
// kfs_dp
// Datapath: coefficients, filter state, scratch RAM, multiply-accumulate
// and the reciprocal unit.
// ---------------------------------------------------------------------------
module kfs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kfs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [kfs_pkg::CW-1:0]        cfg_data,
  input  logic [4*kfs_pkg::DW-1:0]      in_tdata,
  input  kfs_pkg::cmd_t                 cmd,
  output kfs_pkg::sts_t                 sts,
  output logic [6*kfs_pkg::DW-1:0]      out_tdata,
  output logic [1:0]                    out_tuser
);

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  kfs_pkg::ins_t ins;

  logic [kfs_pkg::CW-1:0]        cfg_r [kfs_pkg::CFG_N];
  logic signed [kfs_pkg::DW-1:0] x_r [2];
  logic signed [kfs_pkg::DW-1:0] p_r [4];
  logic signed [kfs_pkg::DW-1:0] z0_r, z1_r, u0_r, u1_r;
  logic signed [63:0]            term_r, base_r, acc_r;
  logic                          sat_r, sing_r;
  logic [6*kfs_pkg::DW-1:0]      out_data_r;
  logic [1:0]                    out_user_r;

  logic [kfs_pkg::DW-1:0]        ram_qa, ram_qb, ram_wdata;
  logic                          ram_we;
  logic signed [kfs_pkg::DW-1:0] op_a, op_b, sat_v;
  logic signed [63:0]            prod, shifted, term_nxt, base_nxt, sum;
  logic                          clip;
  logic                          div_done, div_clip, div_zero;
  logic [kfs_pkg::DW-1:0]        div_q;

  assign ins = cmd.ins;

  function automatic logic signed [kfs_pkg::DW-1:0] coef_at(logic [kfs_pkg::IDX_W-1:0] i);
    logic [2:0]         rsel;
    logic [15:0]        ent;
    logic signed [31:0] v;
    rsel = i[4:2];
    ent  = '0;
    if (rsel < 3'(kfs_pkg::CFG_N)) begin
      ent = cfg_r[rsel][16*i[1:0] +: 16];
    end
    v = 32'(signed'(ent));
    // noise covariances widen from Q8.8 to Q16.16
    if (rsel >= kfs_pkg::CREG_Q) begin
      v = v <<< 8;
    end
    return v;
  endfunction

  function automatic logic signed [kfs_pkg::DW-1:0] ext_at(logic [kfs_pkg::IDX_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      kfs_pkg::E_X0:  v = x_r[0];
      kfs_pkg::E_X1:  v = x_r[1];
      kfs_pkg::E_P00: v = p_r[0];
      kfs_pkg::E_P01: v = p_r[1];
      kfs_pkg::E_P10: v = p_r[2];
      kfs_pkg::E_P11: v = p_r[3];
      kfs_pkg::E_Z0:  v = z0_r;
      kfs_pkg::E_Z1:  v = z1_r;
      kfs_pkg::E_U0:  v = u0_r;
      kfs_pkg::E_U1:  v = u1_r;
      default:        v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [kfs_pkg::DW-1:0] opnd_at(kfs_pkg::opnd_t o,
                                                            logic [kfs_pkg::DW-1:0] q);
    logic signed [31:0] v;
    case (o.src)
      kfs_pkg::S_RAM:  v = signed'(q);
      kfs_pkg::S_COEF: v = coef_at(o.idx);
      kfs_pkg::S_EXT:  v = ext_at(o.idx);
      default:         v = '0;
    endcase
    return v;
  endfunction

  kfs_ram #(.WIDTH(kfs_pkg::DW), .DEPTH(kfs_pkg::RAM_D)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ins.dst),
    .wdata   (ram_wdata),
    .raddr_a (ins.a.idx),
    .rdata_a (ram_qa),
    .raddr_b (ins.b.idx),
    .rdata_b (ram_qb)
  );

  kfs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (ram_qa),
    .done    (div_done),
    .quo     (div_q),
    .clip    (div_clip),
    .zero    (div_zero)
  );

  assign sts.div_done = div_done;

  // operand fetch and multiply
  always_comb begin
    op_a    = opnd_at(ins.a, ram_qa);
    op_b    = opnd_at(ins.b, ram_qb);
    prod    = op_a * op_b;
    shifted = ins.sh16 ? (prod >>> 16) : (prod >>> 8);
    case (ins.mode)
      kfs_pkg::M_MUL: term_nxt = shifted;
      kfs_pkg::M_ADD: term_nxt = 64'(op_b);
      kfs_pkg::M_SUB: term_nxt = -64'(op_b);
      default:        term_nxt = '0;
    endcase
    base_nxt = (ins.mode == kfs_pkg::M_MUL) ? 64'sd0 : 64'(op_a);
  end

  // accumulate and clip
  always_comb begin
    sum  = (ins.acc ? acc_r : base_r) + term_r;
    clip = 1'b0;
    if (sum > SAT_MAX) begin
      sat_v = 32'sh7FFF_FFFF;
      clip  = 1'b1;
    end else if (sum < SAT_MIN) begin
      sat_v = 32'sh8000_0000;
      clip  = 1'b1;
    end else begin
      sat_v = sum[31:0];
    end
  end

  assign ram_we    = (cmd.wb && ins.dk == kfs_pkg::D_RAM) || cmd.div_wr;
  assign ram_wdata = cmd.div_wr ? div_q : sat_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= kfs_pkg::CFG_RST_IDENT;
      cfg_r[1] <= kfs_pkg::CFG_RST_IDENT;
      cfg_r[2] <= kfs_pkg::CFG_RST_IDENT;
      cfg_r[3] <= kfs_pkg::CFG_RST_ONES;
      cfg_r[4] <= kfs_pkg::CFG_RST_ONES;
      x_r[0]   <= '0;
      x_r[1]   <= '0;
      p_r[0]   <= '0;
      p_r[1]   <= '0;
      p_r[2]   <= '0;
      p_r[3]   <= '0;
    end else begin
      // indexes past the register list are dropped
      if (cfg_we && cfg_index < 3'(kfs_pkg::CFG_N)) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      if (cmd.wb && ins.dk == kfs_pkg::D_STATE) begin
        case (ins.dst)
          kfs_pkg::E_X0:  x_r[0] <= sat_v;
          kfs_pkg::E_X1:  x_r[1] <= sat_v;
          kfs_pkg::E_P00: p_r[0] <= sat_v;
          kfs_pkg::E_P01: p_r[1] <= sat_v;
          kfs_pkg::E_P10: p_r[2] <= sat_v;
          kfs_pkg::E_P11: p_r[3] <= sat_v;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      z0_r   <= in_tdata[31:0];
      z1_r   <= in_tdata[63:32];
      u0_r   <= in_tdata[95:64];
      u1_r   <= in_tdata[127:96];
      sat_r  <= 1'b0;
      sing_r <= 1'b0;
    end else begin
      if (cmd.wb && ins.dk != kfs_pkg::D_NONE && clip) begin
        sat_r <= 1'b1;
      end
      if (cmd.div_wr) begin
        sing_r <= div_zero;
        if (div_clip) begin
          sat_r <= 1'b1;
        end
      end
    end
    if (cmd.ex) begin
      term_r <= term_nxt;
      base_r <= base_nxt;
    end
    if (cmd.wb) begin
      acc_r <= sum;
    end
    if (cmd.out_load) begin
      out_data_r <= {p_r[3], p_r[2], p_r[1], p_r[0], x_r[1], x_r[0]};
      out_user_r <= {sat_r, sing_r};
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

@@ sv/kfs_ctrl.sv @@
// ---------------------------------------------------------------------------
// kfs_ctrl
// Controller: steps the micro-program, runs the handshakes.
// ---------------------------------------------------------------------------
module kfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  kfs_pkg::sts_t sts,
  output kfs_pkg::cmd_t cmd
);

  kfs_pkg::ctl_state_t       state_r, state_nxt;
  logic [kfs_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  kfs_pkg::ins_t             ins;
  logic                      last;

  assign ins  = kfs_pkg::ucode(pc_r);
  assign last = pc_r == kfs_pkg::PC_W'(kfs_pkg::PROG_LEN - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kfs_pkg::ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kfs_pkg::ST_IDLE: if (in_tvalid) state_nxt = kfs_pkg::ST_RD;
      kfs_pkg::ST_RD:   state_nxt = kfs_pkg::ST_EX;
      kfs_pkg::ST_EX:   state_nxt = (ins.mode == kfs_pkg::M_DIV) ? kfs_pkg::ST_DIV
                                                                 : kfs_pkg::ST_WB;
      kfs_pkg::ST_WB:   state_nxt = last ? kfs_pkg::ST_OUT : kfs_pkg::ST_RD;
      kfs_pkg::ST_DIV:  if (sts.div_done) state_nxt = kfs_pkg::ST_RD;
      kfs_pkg::ST_OUT:  if (!out_valid_r || out_tready) state_nxt = kfs_pkg::ST_IDLE;
      default:          state_nxt = kfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.ins       = ins;
    in_tready     = 1'b0;
    case (state_r)
      kfs_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      kfs_pkg::ST_EX: begin
        cmd.ex        = ins.mode != kfs_pkg::M_DIV;
        cmd.div_start = ins.mode == kfs_pkg::M_DIV;
      end
      kfs_pkg::ST_WB:  cmd.wb       = 1'b1;
      kfs_pkg::ST_DIV: cmd.div_wr   = sts.div_done;
      kfs_pkg::ST_OUT: cmd.out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (cmd.accept) begin
      pc_nxt = '0;
    end else if ((cmd.wb && !last) || cmd.div_wr) begin
      pc_nxt = pc_r + 1'b1;
    end
    // hold the word until taken, refill in the same cycle
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ sv/kalman_filter_step_core.sv @@
// ---------------------------------------------------------------------------
// kalman_filter_step_core
// One linear Kalman filter iteration (predict, gain, update) per word.
// ---------------------------------------------------------------------------
// Use:
//   Write A, B, H, Q and R on the cfg channel (index 0..4) while idle;
//   cfg_ready is always high and indexes above 4 are dropped.
//   Each in_ word carries a measurement and a control vector; the core
//   answers with one out_ word: new state estimate, new covariance and the
//   singular / saturated flags in out_tuser.
// Timing:
//   An item runs a 63-step micro-program on one shared 32x32 multiplier;
//   each step runs a scratch RAM read, a multiply and an accumulate state;
//   the reciprocal step waits on the 33-step serial divider instead of
//   accumulating, and skips the divider when the innovation covariance is
//   zero. out_tvalid rises once the result enters the output register, and
//   the next input is taken only after that load; one item is in flight.
// Reset:
//   State and covariance clear to zero, A, B and H to identity, Q and R to
//   all ones; no item or result is pending.
// Stall:
//   A result waits in the output register for out_tready; the next input
//   is taken meanwhile and its result waits in turn until the slot frees.
// ---------------------------------------------------------------------------
`include "kalman_filter_step_core_macros.svh"

module kalman_filter_step_core (
  input  logic         clk,
  input  logic         rst_n,
  // config write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  // input: meas_0, meas_1, ctrl_0, ctrl_1 (32 bits each, low to high)
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  // result: est_0, est_1, cov_00, cov_01, cov_10, cov_11 (32 bits each)
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,
  // result flags: singular, saturated (low to high)
  output logic [1:0]   out_tuser
);

  kfs_pkg::cmd_t cmd;
  kfs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  kfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  kfs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  `KFSC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while a step runs")
  `KFSC_ASSERT_NOW(a_load_slot_free, clk, rst_n, cmd.out_load, !out_tvalid || out_tready, "result overwrote a waiting word")
  `KFSC_ASSERT_NOW(a_div_wr_done, clk, rst_n, cmd.div_wr, sts.div_done, "reciprocal written before divider finished")

endmodule
